// ===== sv/vertex_rotate_project_unit_defines.svh =====
// Assertion helpers for the vertex rotate/project unit.
`ifndef VERTEX_ROTATE_PROJECT_UNIT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define VRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define VRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VRP_ASSERT(lbl, prop, msg)
`define VRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/vrp_pkg.sv =====
package vrp_pkg;

    localparam int CW      = 18;  // CORDIC x/y
    localparam int ZW      = 17;  // CORDIC residual phase
    localparam int ITER    = 16;
    localparam int CS_W    = 16;  // clamped sine/cosine, Q2.14
    localparam int VC_W    = 19;  // rotated coordinates, Q.12
    localparam int DIST_W  = 20;
    localparam int DEN_W   = 27;
    localparam int NUM_W   = 39;  // numerator magnitude
    localparam int Q_W     = 12;
    localparam int OUT_W   = 12;

    localparam int SCREEN_W_DEF = 128;
    localparam int SCREEN_H_DEF = 64;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIST  = 8'd1;
    localparam logic [15:0] SCALE_RST = 16'd10240;
    localparam logic [14:0] DIST_RST  = 15'd10240;

    localparam logic signed [CW-1:0] CORDIC_X0 = 18'sd9949;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [ZW-1:0] z;
    } t_cordic_lane;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } t_div_lane;

    // arctan(2^-i) in phase units, 65536 per turn
    function automatic logic [ZW-1:0] atan_phase(input int i);
        logic [ZW-1:0] r;
        case (i)
            0:       r = 17'd8192;
            1:       r = 17'd4836;
            2:       r = 17'd2555;
            3:       r = 17'd1297;
            4:       r = 17'd651;
            5:       r = 17'd326;
            6:       r = 17'd163;
            7:       r = 17'd81;
            8:       r = 17'd41;
            9:       r = 17'd20;
            10:      r = 17'd10;
            11:      r = 17'd5;
            12:      r = 17'd3;
            13:      r = 17'd1;
            14:      r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/vrp_cordic_cell.sv =====
// One CORDIC micro-rotation for three angle lanes.
module vrp_cordic_cell #(
    parameter int STEP  = 0,
    parameter int PAY_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  vrp_pkg::t_cordic_lane [2:0]     i_lane,
    input  logic [PAY_W-1:0]                i_pay,
    output logic                            o_valid,
    output vrp_pkg::t_cordic_lane [2:0]     o_lane,
    output logic [PAY_W-1:0]                o_pay
);
    localparam logic [vrp_pkg::ZW-1:0] ATAN = vrp_pkg::atan_phase(STEP);

    logic                        r_valid;
    vrp_pkg::t_cordic_lane [2:0] r_lane, n_lane;
    logic [PAY_W-1:0]            r_pay;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!i_lane[l].z[vrp_pkg::ZW-1]) begin
                n_lane[l].x = i_lane[l].x - vrp_pkg::CW'($signed(i_lane[l].y) >>> STEP);
                n_lane[l].y = i_lane[l].y + vrp_pkg::CW'($signed(i_lane[l].x) >>> STEP);
                n_lane[l].z = i_lane[l].z - ATAN;
            end else begin
                n_lane[l].x = i_lane[l].x + vrp_pkg::CW'($signed(i_lane[l].y) >>> STEP);
                n_lane[l].y = i_lane[l].y - vrp_pkg::CW'($signed(i_lane[l].x) >>> STEP);
                n_lane[l].z = i_lane[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_pay   = r_pay;
endmodule

// ===== sv/vrp_div_cell.sv =====
// One restoring-division quotient bit for the x and y lanes (shared divisor).
module vrp_div_cell #(
    parameter int BIT   = 0,
    parameter int PAY_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [vrp_pkg::DEN_W-1:0]     i_den,
    input  vrp_pkg::t_div_lane [1:0]      i_lane,
    input  logic [PAY_W-1:0]              i_pay,
    output logic                          o_valid,
    output logic [vrp_pkg::DEN_W-1:0]     o_den,
    output vrp_pkg::t_div_lane [1:0]      o_lane,
    output logic [PAY_W-1:0]              o_pay
);
    logic                      r_valid;
    logic [vrp_pkg::DEN_W-1:0] r_den;
    vrp_pkg::t_div_lane [1:0]  r_lane, n_lane;
    logic [PAY_W-1:0]          r_pay;
    logic [vrp_pkg::NUM_W-1:0] w_trial;

    assign w_trial = vrp_pkg::NUM_W'(i_den) << BIT;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_lane[l] = i_lane[l];
            if (i_lane[l].rem >= w_trial) begin
                n_lane[l].rem      = i_lane[l].rem - w_trial;
                n_lane[l].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_lane <= n_lane;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_lane  = r_lane;
    assign o_pay   = r_pay;
endmodule

// ===== sv/vertex_rotate_project_unit.sv =====
// Vertex rotate and project unit.
// Slave stream: one transaction per vertex; tdata carries x, y, z (signed Q4.12)
// and the three rotation phases about X, Y, Z (65536 = one turn).
// Master stream: one transaction per vertex; tdata carries screen x and y
// (12-bit signed, truncated toward zero, saturated), tuser the on-screen and
// behind-viewer flags. Behind the viewer, x, y and on-screen read as zero.
// Config channel: index 0 = projection scale (Q8.8), 1 = viewer distance
// (Q4.12); other indexes are ignored. Always ready; write only when idle.
// Throughput: one vertex per cycle while the output is not stalled. Pipeline
// registers from input to output: 1 fold, 16 CORDIC cells, 1 clamp, 3 rotation,
// 3 projection setup, 12 divider cells, 1 output. The whole chain advances together.
// Stall: when the output holds a transaction the receiver has not taken, the
// chain freezes and tready on the slave side drops in the same cycle.
// Reset: synchronous, active low; empties the chain and restores the
// config registers to scale 40.0 and distance 2.5.
`include "vertex_rotate_project_unit_defines.svh"
module vertex_rotate_project_unit #(
    parameter int SCREEN_W = vrp_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = vrp_pkg::SCREEN_H_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] vertex_x, [31:16] vertex_y, [47:32] vertex_z,
    // [63:48] angle_about_x, [79:64] angle_about_y, [95:80] angle_about_z
    input  logic [95:0]                         i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [11:0] screen_x, [23:12] screen_y
    output logic [23:0]                         o_m_axis_tdata,
    // [0] on_screen, [1] behind_viewer
    output logic [1:0]                          o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int CW    = vrp_pkg::CW;
    localparam int ZW    = vrp_pkg::ZW;
    localparam int CS_W  = vrp_pkg::CS_W;
    localparam int VC_W  = vrp_pkg::VC_W;
    localparam int NUM_W = vrp_pkg::NUM_W;
    localparam int DEN_W = vrp_pkg::DEN_W;
    localparam int Q_W   = vrp_pkg::Q_W;
    localparam int ITER  = vrp_pkg::ITER;
    localparam int CP_W  = 51;   // {neg[2:0], vz, vy, vx}
    localparam int DP_W  = 5;    // {behind, ovf_y, ovf_x, sgn_y, sgn_x}
    localparam logic [NUM_W:0] CENTER_X = (NUM_W + 1)'(SCREEN_W / 2);
    localparam logic [NUM_W:0] CENTER_Y = (NUM_W + 1)'(SCREEN_H / 2);

    // chain enable: move whenever the output slot is free or being drained
    logic w_en;
    logic r_out_valid;
    assign w_en = !r_out_valid || i_m_axis_tready;

    // ---------------- configuration registers ----------------
    logic [15:0] r_scale;
    logic [14:0] r_vdist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= vrp_pkg::SCALE_RST;
            r_vdist <= vrp_pkg::DIST_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == vrp_pkg::REG_PROJ_SCALE) begin
                r_scale <= i_cfg_data;
            end else if (i_cfg_index == vrp_pkg::REG_VIEW_DIST) begin
                r_vdist <= i_cfg_data[14:0];
            end
        end
    end
    assign o_cfg_ready = 1'b1;

    // ---------------- phase fold into [-1/4, 1/4) turn ----------------
    localparam logic [CW-1:0] CORDIC_X0_U = vrp_pkg::CORDIC_X0;

    logic                        r_f_valid;
    vrp_pkg::t_cordic_lane [2:0] r_f_lane, n_f_lane;
    logic [CP_W-1:0]             r_f_pay;
    logic [2:0]                  w_neg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [15:0] ang;
            ang         = i_s_axis_tdata[48 + 16*l +: 16];
            w_neg[l]    = ang[15] ^ ang[14];
            if (w_neg[l]) begin
                ang[15] = ~ang[15];
            end
            n_f_lane[l].x = CORDIC_X0_U;
            n_f_lane[l].y = '0;
            n_f_lane[l].z = ZW'($signed(ang));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_lane <= n_f_lane;
            r_f_pay  <= {w_neg, i_s_axis_tdata[47:0]};
        end
    end

    assign o_s_axis_tready = w_en;

    // ---------------- CORDIC chain ----------------
    logic                        w_cv [0:ITER];
    vrp_pkg::t_cordic_lane [2:0] w_cl [0:ITER];
    logic [CP_W-1:0]             w_cp [0:ITER];

    assign w_cv[0] = r_f_valid;
    assign w_cl[0] = r_f_lane;
    assign w_cp[0] = r_f_pay;

    for (genvar g = 0; g < ITER; g++) begin : g_cordic
        vrp_cordic_cell #(
            .STEP  (g),
            .PAY_W (CP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_lane  (w_cl[g]),
            .i_pay   (w_cp[g]),
            .o_valid (w_cv[g+1]),
            .o_lane  (w_cl[g+1]),
            .o_pay   (w_cp[g+1])
        );
    end

    // ---------------- undo fold, clamp sine/cosine ----------------
    function automatic logic signed [CS_W-1:0] clamp_cs(input logic [CW-1:0] v, input logic neg);
        logic signed [CW-1:0] t;
        logic signed [CS_W-1:0] r;
        t = neg ? -$signed(v) : $signed(v);
        if (t > 18'sd16384) begin
            r = 16'sd16384;
        end else if (t < -18'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = t[CS_W-1:0];
        end
        return r;
    endfunction

    logic                   r_c_valid;
    logic signed [CS_W-1:0] r_c_sin [0:2];
    logic signed [CS_W-1:0] r_c_cos [0:2];
    logic [47:0]            r_c_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= w_cv[ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_c_cos[l] <= clamp_cs(w_cl[ITER][l].x, w_cp[ITER][48 + l]);
                r_c_sin[l] <= clamp_cs(w_cl[ITER][l].y, w_cp[ITER][48 + l]);
            end
            r_c_vtx <= w_cp[ITER][47:0];
        end
    end

    // ---------------- rotations X, Y, Z ----------------
    // a*b + c*d rounded from Q.26 to Q.12 (add half, floor shift)
    function automatic logic signed [VC_W-1:0] mac14(
        input logic signed [CS_W-1:0] a, input logic signed [VC_W-1:0] b,
        input logic signed [CS_W-1:0] c, input logic signed [VC_W-1:0] d);
        logic signed [VC_W+16:0] s;
        s = a * b + c * d + (VC_W + 17)'(8192);
        return s[VC_W+13:14];
    endfunction

    logic                   r_r1_valid, r_r2_valid, r_r3_valid;
    logic signed [VC_W-1:0] r_r1_y1, r_r1_z1, r_r1_vx;
    logic signed [VC_W-1:0] r_r2_x2, r_r2_z2, r_r2_y1;
    logic signed [VC_W-1:0] r_r3_x3, r_r3_y3, r_r3_z2;
    logic signed [CS_W-1:0] r_r1_sb, r_r1_cb, r_r1_sc, r_r1_cc, r_r2_sc, r_r2_cc;
    logic signed [VC_W-1:0] w_vx, w_vy, w_vz;

    assign w_vx = VC_W'($signed(r_c_vtx[15:0]));
    assign w_vy = VC_W'($signed(r_c_vtx[31:16]));
    assign w_vz = VC_W'($signed(r_c_vtx[47:32]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
            r_r2_valid <= 1'b0;
            r_r3_valid <= 1'b0;
        end else if (w_en) begin
            r_r1_valid <= r_c_valid;
            r_r2_valid <= r_r1_valid;
            r_r3_valid <= r_r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_y1 <= mac14(r_c_cos[0], w_vy, -r_c_sin[0], w_vz);
            r_r1_z1 <= mac14(r_c_sin[0], w_vy, r_c_cos[0], w_vz);
            r_r1_vx <= w_vx;
            r_r1_sb <= r_c_sin[1];
            r_r1_cb <= r_c_cos[1];
            r_r1_sc <= r_c_sin[2];
            r_r1_cc <= r_c_cos[2];

            r_r2_x2 <= mac14(r_r1_cb, r_r1_vx, r_r1_sb, r_r1_z1);
            r_r2_z2 <= mac14(-r_r1_sb, r_r1_vx, r_r1_cb, r_r1_z1);
            r_r2_y1 <= r_r1_y1;
            r_r2_sc <= r_r1_sc;
            r_r2_cc <= r_r1_cc;

            r_r3_x3 <= mac14(r_r2_cc, r_r2_x2, -r_r2_sc, r_r2_y1);
            r_r3_y3 <= mac14(r_r2_sc, r_r2_x2, r_r2_cc, r_r2_y1);
            r_r3_z2 <= r_r2_z2;
        end
    end

    // ---------------- projection setup ----------------
    logic signed [vrp_pkg::DIST_W-1:0] w_dist;
    assign w_dist = $signed({5'b0, r_vdist}) - vrp_pkg::DIST_W'(r_r3_z2);

    logic                   r_p1_valid, r_p2_valid, r_p3_valid;
    logic                   r_p1_behind, r_p2_behind, r_p3_behind;
    logic [DEN_W-1:0]       r_p1_den, r_p2_den, r_p3_den;
    logic signed [VC_W-1:0] r_p1_x3, r_p1_y3;
    logic signed [NUM_W:0]  r_p2_nx, r_p2_ny;
    vrp_pkg::t_div_lane [1:0] r_p3_lane;
    logic [1:0]             r_p3_sgn, r_p3_ovf;

    logic signed [NUM_W:0]  w_nx, w_ny;
    logic [NUM_W:0]         w_den_ext;
    assign w_den_ext = (NUM_W + 1)'(r_p1_den);
    assign w_nx = $signed(CENTER_X * w_den_ext) + $signed({1'b0, r_scale}) * r_p1_x3;
    assign w_ny = $signed(CENTER_Y * w_den_ext) + $signed({1'b0, r_scale}) * r_p1_y3;

    function automatic logic [NUM_W-1:0] mag_of(input logic signed [NUM_W:0] v);
        logic signed [NUM_W:0] t;
        t = v[NUM_W] ? -v : v;
        return t[NUM_W-1:0];
    endfunction

    logic [NUM_W-1:0] w_mx, w_my, w_lim;
    assign w_mx  = mag_of(r_p2_nx);
    assign w_my  = mag_of(r_p2_ny);
    assign w_lim = {r_p2_den, {Q_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= r_r3_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_behind <= w_dist[vrp_pkg::DIST_W-1] || (w_dist == '0);
            r_p1_den    <= {w_dist[18:0], 8'b0};
            r_p1_x3     <= r_r3_x3;
            r_p1_y3     <= r_r3_y3;

            r_p2_nx     <= w_nx;
            r_p2_ny     <= w_ny;
            r_p2_den    <= r_p1_den;
            r_p2_behind <= r_p1_behind;

            r_p3_lane[0].rem <= w_mx;
            r_p3_lane[0].quo <= '0;
            r_p3_lane[1].rem <= w_my;
            r_p3_lane[1].quo <= '0;
            r_p3_sgn    <= {r_p2_ny[NUM_W], r_p2_nx[NUM_W]};
            r_p3_ovf    <= {w_my >= w_lim, w_mx >= w_lim};
            r_p3_den    <= r_p2_den;
            r_p3_behind <= r_p2_behind;
        end
    end

    // ---------------- divider chain, MSB first ----------------
    logic                     w_dv [0:Q_W];
    logic [DEN_W-1:0]         w_dd [0:Q_W];
    vrp_pkg::t_div_lane [1:0] w_dl [0:Q_W];
    logic [DP_W-1:0]          w_dp [0:Q_W];

    assign w_dv[0] = r_p3_valid;
    assign w_dd[0] = r_p3_den;
    assign w_dl[0] = r_p3_lane;
    assign w_dp[0] = {r_p3_behind, r_p3_ovf, r_p3_sgn};

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        vrp_div_cell #(
            .BIT   (Q_W - 1 - g),
            .PAY_W (DP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_den   (w_dd[g]),
            .i_lane  (w_dl[g]),
            .i_pay   (w_dp[g]),
            .o_valid (w_dv[g+1]),
            .o_den   (w_dd[g+1]),
            .o_lane  (w_dl[g+1]),
            .o_pay   (w_dp[g+1])
        );
    end

    // ---------------- sign, saturate, bounds test ----------------
    function automatic logic [Q_W-1:0] sat_axis(input logic [Q_W-1:0] mag,
                                                input logic sgn, input logic ovf);
        logic [Q_W-1:0] r;
        if (!sgn) begin
            r = (ovf || mag[Q_W-1]) ? 12'h7FF : mag;
        end else begin
            r = (ovf || (mag > 12'd2048)) ? 12'h800 : -mag;
        end
        return r;
    endfunction

    logic [Q_W-1:0] w_sx, w_sy;
    logic           w_behind, w_on;
    assign w_behind = w_dp[Q_W][4];
    assign w_sx = sat_axis(w_dl[Q_W][0].quo, w_dp[Q_W][0], w_dp[Q_W][2]);
    assign w_sy = sat_axis(w_dl[Q_W][1].quo, w_dp[Q_W][1], w_dp[Q_W][3]);
    assign w_on = !w_sx[Q_W-1] && ({1'b0, w_sx} < (Q_W + 1)'(SCREEN_W)) &&
                  !w_sy[Q_W-1] && ({1'b0, w_sy} < (Q_W + 1)'(SCREEN_H));

    logic [Q_W-1:0] r_sx, r_sy;
    logic           r_on, r_behind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_behind <= w_behind;
            r_sx     <= w_behind ? '0 : w_sx;
            r_sy     <= w_behind ? '0 : w_sy;
            r_on     <= w_behind ? 1'b0 : w_on;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_sy, r_sx};
    assign o_m_axis_tuser  = {r_behind, r_on};

    // ---------------- checks ----------------
    `VRP_ASSERT(a_behind_zeroes, (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[0]), "behind-viewer result with nonzero position")
    `VRP_ASSERT(a_on_in_range, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (!o_m_axis_tdata[11] && !o_m_axis_tdata[23]), "on-screen flag with negative coordinate")
    `VRP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Screen size of the block as instantiated (its parameter defaults).
localparam int SCR_W = vrp_pkg::SCREEN_W_DEF;
localparam int SCR_H = vrp_pkg::SCREEN_H_DEF;

typedef struct {
    logic [15:0] vx, vy, vz;
    logic [15:0] ax, ay, az;
} vertex_t;

typedef struct {
    logic [11:0] sx, sy;
    logic        on_scr, behind;
} pixel_t;

// Projection predictor and queue of expected screen positions.
class pixel_scoreboard;
    logic [15:0] scale;
    logic [14:0] vdist;
    pixel_t      pending[$];
    int          fails;

    function new();
        scale = 16'd10240;
        vdist = 15'd10240;
        fails = 0;
    endfunction

    // CORDIC in Q2.14, rotation mode, phase folded into [-1/4, 1/4) turn
    static function void sin_cos(input logic [15:0] ph, output int s, output int c);
        int atan_ph [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                             41, 20, 10, 5, 3, 1, 1, 0};
        int z, x, y, dx, dy;
        bit neg;
        z = int'($signed(ph));
        neg = 0;
        x = 9949;
        y = 0;
        if (z >= 16384 || z < -16384) begin
            z = int'($signed(16'(z + 32768)));
            neg = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_ph[i];
            end else begin
                x += dx; y -= dy; z += atan_ph[i];
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = x < -16384 ? -16384 : (x > 16384 ? 16384 : x);
        s = y < -16384 ? -16384 : (y > 16384 ? 16384 : y);
    endfunction

    // a*b + c*d, rounded from Q.26 to Q.12 (floor after adding half)
    static function int dot_round(int a, int b, int c, int d);
        longint acc;
        acc = longint'(a) * b + longint'(c) * d + 8192;
        return int'(acc >>> 14);
    endfunction

    function int project(int coord, longint depth, int center);
        longint den, num, q;
        den = depth * 256;
        num = longint'(center) * den + longint'(scale) * coord;
        q = num / den;  // truncates toward zero
        if (q > 2047)  q = 2047;
        if (q < -2048) q = -2048;
        return int'(q);
    endfunction

    function void note_vertex(vertex_t v);
        int sa, ca, sb, cb, sc, cc, vx, vy, vz, y1, z1, x2, z2, x3, y3, px, py;
        longint depth;
        pixel_t e;
        vx = int'($signed(v.vx));
        vy = int'($signed(v.vy));
        vz = int'($signed(v.vz));
        sin_cos(v.ax, sa, ca);
        sin_cos(v.ay, sb, cb);
        sin_cos(v.az, sc, cc);
        y1 = dot_round(ca, vy, -sa, vz);
        z1 = dot_round(sa, vy, ca, vz);
        x2 = dot_round(cb, vx, sb, z1);
        z2 = dot_round(-sb, vx, cb, z1);
        x3 = dot_round(cc, x2, -sc, y1);
        y3 = dot_round(sc, x2, cc, y1);
        depth = longint'(vdist) - z2;
        e = '{12'd0, 12'd0, 1'b0, 1'b0};
        if (depth <= 0) begin
            e.behind = 1'b1;
        end else begin
            px = project(x3, depth, SCR_W / 2);
            py = project(y3, depth, SCR_H / 2);
            e.sx = px[11:0];
            e.sy = py[11:0];
            e.on_scr = (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H);
        end
        pending.push_back(e);
    endfunction

    function void check_pixel(logic [23:0] data, logic [1:0] flags);
        pixel_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h flags=%b", $time, data, flags);
            fails++;
            return;
        end
        e = pending.pop_front();
        if (data[11:0] !== e.sx) begin
            $display("%0t: screen_x expected %0d actual %0d", $time,
                     $signed(e.sx), $signed(data[11:0]));
            fails++;
        end
        if (data[23:12] !== e.sy) begin
            $display("%0t: screen_y expected %0d actual %0d", $time,
                     $signed(e.sy), $signed(data[23:12]));
            fails++;
        end
        if (flags[0] !== e.on_scr) begin
            $display("%0t: on_screen expected %b actual %b", $time, e.on_scr, flags[0]);
            fails++;
        end
        if (flags[1] !== e.behind) begin
            $display("%0t: behind_viewer expected %b actual %b", $time,
                     e.behind, flags[1]);
            fails++;
        end
    endfunction
endclass

module tb;
    // Index with no register behind it; writes must leave state alone.
    localparam logic [vrp_pkg::CFG_IDX_W-1:0] REG_NONE = 8'd2;
    localparam int PIPE_CYCLES = 45;     // covers the block's pipeline depth, plus margin
    localparam int HOLD_CYCLES = 300;    // long receiver stall; the whole chain freezes
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;   // x, y, z, angle x, angle y, angle z
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // screen_x, screen_y
    logic [1:0]  o_m_axis_tuser;        // on_screen, behind_viewer
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [vrp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [vrp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pixel_scoreboard sb = new();
    bit  no_idle = 0;   // set during the burst phase: neither side idles
    int  hold_reqs = 0; // bumped by the stimulus to ask for a long stall
    int  holds_done = 0;
    int  hold_left = 0;
    int  cycles = 0;

    vertex_rotate_project_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: check each output transaction, then choose next tready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pixel(o_m_axis_tdata, o_m_axis_tuser);
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (holds_done != hold_reqs) begin
            holds_done <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    task automatic send_vertex(vertex_t v);
        if (!no_idle && $urandom_range(99) < 19) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {v.az, v.ay, v.ax, v.vz, v.vy, v.vx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_vertex(v);
    endtask

    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits out every pending result plus the pipeline depth.
    task automatic drain();
        end_burst();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [vrp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == vrp_pkg::REG_PROJ_SCALE)
            sb.scale = val;
        else if (idx == vrp_pkg::REG_VIEW_DIST)
            sb.vdist = val[14:0];
    endtask

    function automatic vertex_t mk(int x, int y, int z, int a, int b, int c);
        vertex_t v;
        v.vx = x[15:0]; v.vy = y[15:0]; v.vz = z[15:0];
        v.ax = a[15:0]; v.ay = b[15:0]; v.az = c[15:0];
        return v;
    endfunction

    // Mostly vertices within +-2.0 so many land on screen; rest anywhere.
    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.ax = $urandom(); v.ay = $urandom(); v.az = $urandom();
        if ($urandom_range(99) < 70) begin
            v.vx = 16'($signed($urandom_range(16384)) - 8192);
            v.vy = 16'($signed($urandom_range(16384)) - 8192);
            v.vz = 16'($signed($urandom_range(16384)) - 8192);
        end else begin
            v.vx = $urandom(); v.vy = $urandom(); v.vz = $urandom();
        end
        return v;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_vertex());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axes, quarter-turn fold boundaries, field extremes,
        // behind-viewer and saturated projections at reset settings.
        send_vertex(mk(0, 0, 0, 0, 0, 0));
        send_vertex(mk(4096, 4096, 0, 0, 0, 0));
        send_vertex(mk(4096, 0, 0, 16384, 0, 0));       // folded at +1/4 turn
        send_vertex(mk(0, 4096, 0, 49152, 0, 0));       // -1/4 turn, not folded
        send_vertex(mk(0, 0, 4096, 16383, 32768, 0));
        send_vertex(mk(4096, 0, 0, 0, 0, 65535));
        send_vertex(mk(2048, -2048, 1024, 32768, 49152, 16384));
        send_vertex(mk(32767, 32767, 32767, 0, 0, 0));
        send_vertex(mk(-32768, -32768, -32768, 0, 0, 0));
        send_vertex(mk(0, 0, 10240, 0, 0, 0));          // depth exactly zero
        send_vertex(mk(0, 0, 10239, 0, 0, 0));          // depth one LSB
        send_vertex(mk(32767, -32768, 10230, 0, 0, 0)); // saturates both ways
        send_vertex(mk(-32768, 32767, 0, 65535, 65535, 65535));
        send_vertex(mk(12000, 8000, -30000, 8192, 24576, 40960));
        drain();

        random_run(225);
        drain();

        // Largest scale, distance one LSB: saturation and behind-viewer heavy.
        write_reg(vrp_pkg::REG_PROJ_SCALE, 16'hFFFF);
        write_reg(vrp_pkg::REG_VIEW_DIST, 16'h0001);
        send_vertex(mk(1, -1, -1, 0, 0, 0));
        send_vertex(mk(0, 0, 0, 0, 0, 0));
        random_run(100);
        hold_reqs++;        // receiver stalls while inputs keep coming
        random_run(125);
        drain();

        // Zero scale, widest distance (top data bit is dropped); no idling.
        write_reg(vrp_pkg::REG_PROJ_SCALE, 16'h0000);
        write_reg(vrp_pkg::REG_VIEW_DIST, 16'hFFFF);
        no_idle = 1;
        random_run(225);
        drain();
        no_idle = 0;

        // Writes to an unused index must not change anything.
        write_reg(REG_NONE, 16'h1234);
        write_reg(8'hFF, 16'hFFFF);
        random_run(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_reg(vrp_pkg::REG_PROJ_SCALE, 16'($urandom()));
            write_reg(vrp_pkg::REG_VIEW_DIST, 16'($urandom()));
            random_run(160);
            drain();
        end

        write_reg(vrp_pkg::REG_PROJ_SCALE, 16'd10240);
        write_reg(vrp_pkg::REG_VIEW_DIST, 16'd0);
        random_run(80);
        drain();

        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
